>>> hw/rtl/cntmax_pkg.sv
// shared types and constants of the counter bank with maximum tracking
package cntmax_pkg;

   localparam int MODE_WIDTH  = 2;
   localparam int INDEX_WIDTH = 8;
   localparam int POP_WIDTH   = 9;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_INC  = 2'd0,
      MODE_DEC  = 2'd1,
      MODE_CLR  = 2'd2,
      MODE_READ = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_HIST_OLD,
      S_HIST_NEW,
      S_SCAN,
      S_DONE
   } state_type;

endpackage

>>> hw/rtl/counter_set_max_tracker.sv
// bank of saturating signed counters with running maximum and its population
//
// A bank of NUM_COUNTERS signed counters of COUNT_WIDTH bits, all zero after
// reset. Each request transfer names a counter and an operation (increment,
// decrement, clear to zero, read). Every request gives one response transfer
// carrying the addressed counter's value afterwards, the largest value of the
// whole bank and how many counters hold it. Increment and decrement saturate
// at the ends of the range and then change nothing; an index at or above
// NUM_COUNTERS changes nothing and returns a counter value of zero. Counters
// live in one synchronous memory and a histogram of counter values (one bucket
// per representable value) in a second one, both with registered read data.
// After reset a clearing pass writes every entry of both memories, one entry a
// cycle, before the first request is taken. A request that changes nothing
// goes from the counter read straight to its response; one that moves a
// counter then does two read-modify-writes on the histogram memory, old
// bucket first, then new bucket. When the last counter at the maximum moves
// down, a downward scan of the histogram, one bucket read at a time from the
// bucket below the old maximum, finds the new maximum. One request is in flight
// at a time; a finished response waits in the output register while the next
// request is accepted.
module counter_set_max_tracker #(
   parameter int NUM_COUNTERS = 256,
   parameter int COUNT_WIDTH  = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [cntmax_pkg::MODE_WIDTH-1:0]  req_mode,
   input  logic [cntmax_pkg::INDEX_WIDTH-1:0] req_index,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [COUNT_WIDTH-1:0]      rsp_counter_value,
   output logic signed [COUNT_WIDTH-1:0]      rsp_max_value,
   output logic [cntmax_pkg::POP_WIDTH-1:0]   rsp_num_at_max
);
   import cntmax_pkg::*;

   localparam int CW          = COUNT_WIDTH;
   // only indexes reachable through the request port need storage
   localparam int IDX_SPAN    = 1 << INDEX_WIDTH;
   localparam int CNT_DEPTH   = (NUM_COUNTERS < IDX_SPAN) ? NUM_COUNTERS : IDX_SPAN;
   localparam int CAW         = (CNT_DEPTH > 1) ? $clog2(CNT_DEPTH) : 1;
   localparam int NUM_BUCKETS = 1 << CW;
   localparam int HW          = $clog2(NUM_COUNTERS + 1);
   localparam int CLR_LEN     = (NUM_BUCKETS > CNT_DEPTH) ? NUM_BUCKETS : CNT_DEPTH;
   localparam int PTRW        = $clog2(CLR_LEN);

   localparam logic [CW-1:0]   SIGN_MASK = {1'b1, {(CW-1){1'b0}}};
   localparam logic [CW-1:0]   VAL_MAX   = ~SIGN_MASK;
   localparam logic [CW-1:0]   VAL_MIN   = SIGN_MASK;
   localparam logic [PTRW-1:0] CLR_LAST  = PTRW'(CLR_LEN - 1);

   // memories
   logic [CW-1:0] cnt_mem  [CNT_DEPTH];
   logic [HW-1:0] hist_mem [NUM_BUCKETS];
   logic [CW-1:0] cnt_rdata_ff;
   logic [HW-1:0] hist_rdata_ff;

   // memory port controls
   logic           cnt_we;
   logic [CAW-1:0] cnt_waddr;
   logic [CW-1:0]  cnt_wdata;
   logic [CAW-1:0] cnt_raddr;
   logic           hist_we;
   logic [CW-1:0]  hist_waddr;
   logic [HW-1:0]  hist_wdata;
   logic [CW-1:0]  hist_raddr;

   // control and working registers
   state_type       state_ff, state_in;
   logic [PTRW-1:0] clr_ptr_ff, clr_ptr_in;
   mode_type        mode_ff, mode_in;
   logic            in_range_ff, in_range_in;
   logic [CAW-1:0]  idx_ff, idx_in;
   logic [CW-1:0]   old_ff, old_in;
   logic [CW-1:0]   new_ff, new_in;
   logic [CW-1:0]   cur_ff, cur_in;
   logic [CW-1:0]   max_ff, max_in;
   logic [HW-1:0]   pop_ff, pop_in;
   logic [CW-1:0]   scan_ptr_ff, scan_ptr_in;
   logic [CW-1:0]   chk_ptr_ff, chk_ptr_in;
   logic            chk_vld_ff, chk_vld_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]        rsp_cv_ff, rsp_cv_in;
   logic [CW-1:0]        rsp_max_ff, rsp_max_in;
   logic [POP_WIDTH-1:0] rsp_pop_ff, rsp_pop_in;

   // helpers
   logic                    out_free;
   logic [CW-1:0]           next_val;
   logic                    scan_hit;
   logic [HW+POP_WIDTH-1:0] pop_ext;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign scan_hit  = chk_vld_ff && (hist_rdata_ff != '0);
   assign pop_ext   = {{POP_WIDTH{1'b0}}, pop_ff};

   // counter value after the requested operation, saturating at the ends
   always_comb begin
      next_val = cnt_rdata_ff;
      case (mode_ff)
         MODE_INC: begin
            if (cnt_rdata_ff != VAL_MAX) next_val = cnt_rdata_ff + CW'(1);
         end
         MODE_DEC: begin
            if (cnt_rdata_ff != VAL_MIN) next_val = cnt_rdata_ff - CW'(1);
         end
         MODE_CLR: begin
            next_val = '0;
         end
         default: begin
            next_val = cnt_rdata_ff;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ptr_ff == CLR_LAST) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_READ;
         end
         S_READ: begin
            if (!in_range_ff || next_val == cnt_rdata_ff) state_in = S_DONE;
            else state_in = S_HIST_OLD;
         end
         S_HIST_OLD: begin
            state_in = S_HIST_NEW;
         end
         S_HIST_NEW: begin
            if ($signed(new_ff) < $signed(max_ff) && old_ff == max_ff &&
                pop_ff == HW'(1)) begin
               state_in = S_SCAN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_SCAN: begin
            if (scan_hit) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // datapath and memory controls
   always_comb begin
      req_ready    = 1'b0;
      clr_ptr_in   = clr_ptr_ff;
      mode_in      = mode_ff;
      in_range_in  = in_range_ff;
      idx_in       = idx_ff;
      old_in       = old_ff;
      new_in       = new_ff;
      cur_in       = cur_ff;
      max_in       = max_ff;
      pop_in       = pop_ff;
      scan_ptr_in  = scan_ptr_ff;
      chk_ptr_in   = chk_ptr_ff;
      chk_vld_in   = chk_vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_cv_in    = rsp_cv_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_pop_in   = rsp_pop_ff;
      cnt_we       = 1'b0;
      cnt_waddr    = idx_ff;
      cnt_wdata    = new_ff;
      cnt_raddr    = idx_ff;
      hist_we      = 1'b0;
      hist_waddr   = old_ff ^ SIGN_MASK;
      hist_wdata   = hist_rdata_ff;
      hist_raddr   = old_ff ^ SIGN_MASK;

      case (state_ff)
         S_CLEAR: begin
            // zero every counter, put the whole bank into the zero bucket
            clr_ptr_in = clr_ptr_ff + PTRW'(1);
            cnt_waddr  = clr_ptr_ff[CAW-1:0];
            cnt_wdata  = '0;
            cnt_we     = ({1'b0, clr_ptr_ff} < (PTRW+1)'(CNT_DEPTH));
            hist_waddr = clr_ptr_ff[CW-1:0];
            hist_wdata = (clr_ptr_ff[CW-1:0] == SIGN_MASK) ? HW'(NUM_COUNTERS) : '0;
            hist_we    = ({1'b0, clr_ptr_ff} < (PTRW+1)'(NUM_BUCKETS));
         end
         S_IDLE: begin
            req_ready   = 1'b1;
            mode_in     = mode_type'(req_mode);
            in_range_in = ({{(32-INDEX_WIDTH){1'b0}}, req_index} < 32'(NUM_COUNTERS));
            idx_in      = req_index[CAW-1:0];
            cnt_raddr   = req_index[CAW-1:0];
         end
         S_READ: begin
            old_in     = cnt_rdata_ff;
            new_in     = next_val;
            cur_in     = in_range_ff ? next_val : '0;
            cnt_wdata  = next_val;
            cnt_we     = in_range_ff && (next_val != cnt_rdata_ff);
            hist_raddr = cnt_rdata_ff ^ SIGN_MASK;
         end
         S_HIST_OLD: begin
            // old bucket loses one, fetch the new bucket
            hist_waddr = old_ff ^ SIGN_MASK;
            hist_wdata = hist_rdata_ff - HW'(1);
            hist_we    = 1'b1;
            hist_raddr = new_ff ^ SIGN_MASK;
         end
         S_HIST_NEW: begin
            hist_waddr = new_ff ^ SIGN_MASK;
            hist_wdata = hist_rdata_ff + HW'(1);
            hist_we    = 1'b1;
            if ($signed(new_ff) > $signed(max_ff)) begin
               max_in = new_ff;
               pop_in = HW'(1);
            end else if (new_ff == max_ff) begin
               pop_in = pop_ff + HW'(1);
            end else if (old_ff == max_ff) begin
               pop_in      = pop_ff - HW'(1);
               // one left the maximum; if it was the last, scan down from the bucket below
               scan_ptr_in = (old_ff ^ SIGN_MASK) - CW'(1);
               chk_vld_in  = 1'b0;
            end
         end
         S_SCAN: begin
            // one bucket read issued per cycle, previous one checked
            hist_raddr  = scan_ptr_ff;
            scan_ptr_in = scan_ptr_ff - CW'(1);
            chk_ptr_in  = scan_ptr_ff;
            chk_vld_in  = 1'b1;
            if (scan_hit) begin
               max_in = chk_ptr_ff ^ SIGN_MASK;
               pop_in = hist_rdata_ff;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_cv_in    = cur_ff;
               rsp_max_in   = max_ff;
               rsp_pop_in   = pop_ext[POP_WIDTH-1:0];
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // counter memory
   always_ff @(posedge clock) begin
      if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
      cnt_rdata_ff <= cnt_mem[cnt_raddr];
   end

   // histogram memory
   always_ff @(posedge clock) begin
      if (hist_we) hist_mem[hist_waddr] <= hist_wdata;
      hist_rdata_ff <= hist_mem[hist_raddr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ptr_ff   <= '0;
         max_ff       <= '0;
         pop_ff       <= HW'(NUM_COUNTERS);
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ptr_ff   <= clr_ptr_in;
         max_ff       <= max_in;
         pop_ff       <= pop_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      in_range_ff <= in_range_in;
      idx_ff      <= idx_in;
      old_ff      <= old_in;
      new_ff      <= new_in;
      cur_ff      <= cur_in;
      scan_ptr_ff <= scan_ptr_in;
      chk_ptr_ff  <= chk_ptr_in;
      rsp_cv_ff   <= rsp_cv_in;
      rsp_max_ff  <= rsp_max_in;
      rsp_pop_ff  <= rsp_pop_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_counter_value = rsp_cv_ff;
   assign rsp_max_value     = rsp_max_ff;
   assign rsp_num_at_max    = rsp_pop_ff;

endmodule
